>>> rtl/qfv_pkg.sv
// Package for the quaternion-from-vector-pair unit: widths, CORDIC angle table
// and the elaboration-time CORDIC gain. No dependencies.
package qfv_pkg;

  // Default and maximum number of CORDIC iterations.
  localparam int DEF_CORDIC_STEPS = 16;
  localparam int ATAN_ENTRIES     = 24;

  // Datapath widths.
  localparam int CW     = 36;  // CORDIC x, y and z
  localparam int TW     = 40;  // half angle before range reduction
  localparam int SQ_W   = 64;  // square root operand
  localparam int SQ_STEPS = 32;  // one result bit per cell
  localparam int NW     = 32;  // divisor (norm of the cross product)
  localparam int QW     = 31;  // quotient bits of the unit axis

  // Angle constants in Q.30.
  localparam longint ATAN0   = 64'd843314857;
  localparam longint HALF_PI = 2 * ATAN0;
  localparam longint PI_Q30  = 4 * ATAN0;
  localparam longint TWO_PI  = 8 * ATAN0;

  // atan(2^-i) in Q.30, rounded.
  function automatic logic signed [CW-1:0] atan_q30(input int idx);
    logic signed [CW-1:0] a;
    begin
      unique case (idx)
        0:  a = 36'sd843314857;
        1:  a = 36'sd497837829;
        2:  a = 36'sd263043837;
        3:  a = 36'sd133525159;
        4:  a = 36'sd67021687;
        5:  a = 36'sd33543516;
        6:  a = 36'sd16775851;
        7:  a = 36'sd8388437;
        8:  a = 36'sd4194283;
        9:  a = 36'sd2097149;
        default: a = CW'(64'sd1 <<< (30 - idx));
      endcase
      return a;
    end
  endfunction

  // Reciprocal of the CORDIC gain in Q.30, rounded, for a given iteration count.
  function automatic longint unsigned gain_inv(input int steps);
    longint unsigned g2;
    longint unsigned v;
    longint unsigned res;
    longint unsigned bt;
    longint unsigned num;
    longint unsigned rem;
    longint unsigned q;
    begin
      g2 = 64'd1 << 60;
      for (int i = 0; i < steps; i++) begin
        g2 = g2 + (g2 >> (2 * i));
      end
      v   = g2;
      res = 0;
      bt  = 64'd1 << 62;
      while (bt > v) bt = bt >> 2;
      while (bt != 0) begin
        if (v >= res + bt) begin
          v   = v - (res + bt);
          res = (res >> 1) + bt;
        end else begin
          res = res >> 1;
        end
        bt = bt >> 2;
      end
      num = (64'd1 << 60) + (res >> 1);
      rem = 0;
      q   = 0;
      for (int i = 61; i >= 0; i--) begin
        rem = {rem[62:0], num[i]};
        if (rem >= res) begin
          rem  = rem - res;
          q[i] = 1'b1;
        end
      end
      return q;
    end
  endfunction

endpackage

>>> rtl/qfv_delay.sv
// Delay line of enabled registers that keeps side data aligned with the cells.
// Depends on nothing.
module qfv_delay #(
  parameter int W     = 1,
  parameter int DEPTH = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  if (DEPTH == 0) begin : g_none
    assign q = d;
  end else begin : g_line
    logic [W-1:0] taps [0:DEPTH-1];

    // Shift one place per enabled cycle.
    always_ff @(posedge clk) begin
      if (en) begin
        taps[0] <= d;
        for (int i = 1; i < DEPTH; i++) begin
          taps[i] <= taps[i-1];
        end
      end
    end

    assign q = taps[DEPTH-1];
  end

endmodule

>>> rtl/qfv_sqrt_cell.sv
// One digit of a pipelined integer square root of a 64-bit operand.
// Depends on qfv_pkg.
module qfv_sqrt_cell
  import qfv_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic            clk,
  input  logic            en,
  input  logic [SQ_W-1:0] v_in,
  input  logic [SQ_W-1:0] res_in,
  output logic [SQ_W-1:0] v_out,
  output logic [SQ_W-1:0] res_out
);

  localparam logic [SQ_W-1:0] BIT = SQ_W'(64'd1 << (62 - 2 * IDX));

  logic [SQ_W:0] trial;

  assign trial = {1'b0, res_in} + {1'b0, BIT};

  // Subtract the trial value when it fits and set this result bit.
  always_ff @(posedge clk) begin
    if (en) begin
      if ({1'b0, v_in} >= trial) begin
        v_out   <= v_in - trial[SQ_W-1:0];
        res_out <= (res_in >> 1) + BIT;
      end else begin
        v_out   <= v_in;
        res_out <= res_in >> 1;
      end
    end
  end

endmodule

>>> rtl/qfv_div_cell.sv
// One quotient bit of a pipelined restoring divider.
// Depends on qfv_pkg.
module qfv_div_cell
  import qfv_pkg::*;
(
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] rem_in,
  input  logic [QW-1:0] low_in,
  input  logic [QW-1:0] quo_in,
  input  logic [NW-1:0] den_in,
  output logic [NW-1:0] rem_out,
  output logic [QW-1:0] low_out,
  output logic [QW-1:0] quo_out,
  output logic [NW-1:0] den_out
);

  logic [NW:0] part;

  assign part = {rem_in, low_in[QW-1]};

  // Bring down the next dividend bit and subtract the divisor when it fits.
  always_ff @(posedge clk) begin
    if (en) begin
      low_out <= low_in << 1;
      den_out <= den_in;
      if (part >= {1'b0, den_in}) begin
        rem_out <= NW'(part - {1'b0, den_in});
        quo_out <= {quo_in[QW-2:0], 1'b1};
      end else begin
        rem_out <= part[NW-1:0];
        quo_out <= {quo_in[QW-2:0], 1'b0};
      end
    end
  end

endmodule

>>> rtl/qfv_cordic_cell.sv
// One CORDIC micro-rotation, in vectoring or rotation mode.
// Depends on qfv_pkg for the angle table and widths.
module qfv_cordic_cell
  import qfv_pkg::*;
#(
  parameter int IDX  = 0,
  parameter bit VECT = 1'b0
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [CW-1:0] x_in,
  input  logic signed [CW-1:0] y_in,
  input  logic signed [CW-1:0] z_in,
  output logic signed [CW-1:0] x_out,
  output logic signed [CW-1:0] y_out,
  output logic signed [CW-1:0] z_out
);

  localparam logic signed [CW-1:0] ANG = atan_q30(IDX);

  logic signed [CW-1:0] xs;
  logic signed [CW-1:0] ys;
  logic                 up;

  assign xs = x_in >>> IDX;
  assign ys = y_in >>> IDX;
  // Vectoring drives y to zero, rotation drives z to zero.
  assign up = VECT ? (y_in > 0) : (z_in < 0);

  always_ff @(posedge clk) begin
    if (en) begin
      if (up) begin
        x_out <= x_in + ys;
        y_out <= y_in - xs;
        z_out <= VECT ? z_in + ANG : z_in + ANG;
      end else begin
        x_out <= x_in - ys;
        y_out <= y_in + xs;
        z_out <= z_in - ANG;
      end
    end
  end

endmodule

>>> rtl/quaternion_from_vector_pair_unit.sv
// Top level of the quaternion-from-vector-pair unit.
// Depends on qfv_pkg, qfv_delay, qfv_sqrt_cell, qfv_div_cell and qfv_cordic_cell.
//
// Usage:
//   The input stream carries one word per rotation: two Q2.14 vectors and a
//   Q4.12 amount in s_tdata, and the kind in s_tuser (0: amount scales the
//   angle between the vectors, 1: amount is the angle in radians). The output
//   stream carries the Q1.14 quaternion in m_tdata and the zero-axis flag in
//   m_tuser, one output word per input word, in order.
//   Throughput is one word per cycle while the cell row is not stalled. The
//   latency is that of the longer of two sides: the square root cells and
//   the acos and sin/cos CORDIC cell rows on the angle side, and the square
//   root and divider cell rows on the axis side, plus the join stages.
//   The whole cell row advances together; when the receiver holds m_tready
//   low with a word waiting, the row stops and s_tready drops until the word
//   is taken. Bubbles inside the row are kept in place.
//   Reset clears all valid flags; no word is in flight after reset and the
//   block accepts input in the first cycle after reset is released.
module quaternion_from_vector_pair_unit
  import qfv_pkg::*;
#(
  parameter int CORDIC_STEPS = DEF_CORDIC_STEPS
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [111:0] s_tdata,   // from_x, from_y, from_z, to_x, to_y, to_z, amount
  input  logic         s_tuser,   // kind
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [63:0]  m_tdata,   // quat_x, quat_y, quat_z, quat_w
  output logic         m_tuser    // axis_zero
);

  localparam int N     = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
  localparam int LA    = 44 + 2 * N;  // stage where sin and cos are ready
  localparam int LC    = 38 + QW;     // stage where the unit axis is ready
  localparam int LT    = (LA > LC) ? LA : LC;
  localparam int TOTAL = LT + 2;
  localparam logic signed [CW-1:0] GAIN_K = CW'(gain_inv(N));

  logic adv;
  logic [TOTAL:1] vld;

  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;
  assign m_tvalid = vld[TOTAL];

  // Valid flags move with the cell row.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[TOTAL-1:1], s_tvalid};
    end
  end

  // Stage 1: all products of the dot and cross terms.
  logic signed [15:0] fx, fy, fz, tx, ty, tz, amt_in;
  logic signed [31:0] pdx, pdy, pdz, pa1, pa2, pb1, pb2, pc1, pc2;
  logic               kind1;
  logic signed [15:0] amt1;

  assign fx     = s_tdata[15:0];
  assign fy     = s_tdata[31:16];
  assign fz     = s_tdata[47:32];
  assign tx     = s_tdata[63:48];
  assign ty     = s_tdata[79:64];
  assign tz     = s_tdata[95:80];
  assign amt_in = s_tdata[111:96];

  always_ff @(posedge clk) begin
    if (adv) begin
      pdx   <= fx * tx;
      pdy   <= fy * ty;
      pdz   <= fz * tz;
      pa1   <= fy * tz;
      pa2   <= fz * ty;
      pb1   <= fz * tx;
      pb2   <= fx * tz;
      pc1   <= fx * ty;
      pc2   <= fy * tx;
      kind1 <= s_tuser;
      amt1  <= amt_in;
    end
  end

  // Stage 2: clamped dot product in Q.30 and the cross product.
  logic signed [33:0] dsum;
  logic signed [33:0] dcl;
  logic signed [31:0] c2;
  logic signed [32:0] cx2, cy2, cz2;
  logic               zero2;

  assign dsum = 34'(pdx) + 34'(pdy) + 34'(pdz);
  always_comb begin
    dcl = dsum;
    if (dsum > 34'sd268435456) dcl = 34'sd268435456;
    if (dsum < -34'sd268435456) dcl = -34'sd268435456;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c2    <= 32'(dcl <<< 2);
      cx2   <= 33'(pa1) - 33'(pa2);
      cy2   <= 33'(pb1) - 33'(pb2);
      cz2   <= 33'(pc1) - 33'(pc2);
      zero2 <= (pa1 == pa2) && (pb1 == pb2) && (pc1 == pc2);
    end
  end

  // ---------------- Angle side ----------------

  // Stage 3: 1 - c^2 for the sine of the angle between the vectors.
  logic [SQ_W-1:0]    v3;
  logic signed [31:0] c3;
  logic signed [63:0] csq;

  assign csq = 64'(c2) * 64'(c2);

  always_ff @(posedge clk) begin
    if (adv) begin
      v3 <= (64'd1 << 60) - csq;
      c3 <= c2;
    end
  end

  // Stages 4 to 35: square root cells.
  logic [SQ_W-1:0] sa_v [0:SQ_STEPS];
  logic [SQ_W-1:0] sa_r [0:SQ_STEPS];
  logic [31:0]     c35;

  assign sa_v[0] = v3;
  assign sa_r[0] = '0;
  for (genvar g = 0; g < SQ_STEPS; g++) begin : g_sqa
    qfv_sqrt_cell #(.IDX(g)) u_cell (
      .clk    (clk),
      .en     (adv),
      .v_in   (sa_v[g]),
      .res_in (sa_r[g]),
      .v_out  (sa_v[g+1]),
      .res_out(sa_r[g+1])
    );
  end

  qfv_delay #(.W(32), .DEPTH(SQ_STEPS)) u_dly_c (
    .clk(clk), .en(adv), .d(c3), .q(c35)
  );

  // Stage 36: start of the acos vectoring; a negative cosine is turned by -pi/2.
  logic signed [CW-1:0] va_x [0:N];
  logic signed [CW-1:0] va_y [0:N];
  logic signed [CW-1:0] va_z [0:N];
  logic signed [31:0]   cn;
  logic signed [CW-1:0] sroot;

  assign cn    = c35;
  assign sroot = CW'(sa_r[SQ_STEPS][31:0]);

  always_ff @(posedge clk) begin
    if (adv) begin
      if (cn < 0) begin
        va_x[0] <= sroot;
        va_y[0] <= -CW'(cn);
        va_z[0] <= CW'(HALF_PI);
      end else begin
        va_x[0] <= CW'(cn);
        va_y[0] <= sroot;
        va_z[0] <= '0;
      end
    end
  end

  for (genvar g = 0; g < N; g++) begin : g_acos
    qfv_cordic_cell #(.IDX(g), .VECT(1'b1)) u_cell (
      .clk  (clk),
      .en   (adv),
      .x_in (va_x[g]),
      .y_in (va_y[g]),
      .z_in (va_z[g]),
      .x_out(va_x[g+1]),
      .y_out(va_y[g+1]),
      .z_out(va_z[g+1])
    );
  end

  // Kind and amount ride alongside to the end of the acos row.
  logic [16:0] ka1, ka_d;

  assign ka1 = {kind1, amt1};
  qfv_delay #(.W(17), .DEPTH(35 + N)) u_dly_ka (
    .clk(clk), .en(adv), .d(ka1), .q(ka_d)
  );

  // Scale the angle by the amount.
  logic signed [51:0] prod_m;
  logic               kind_m;
  logic signed [15:0] amt_m;

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_m <= 52'(va_z[N]) * 52'($signed(ka_d[15:0]));
      kind_m <= ka_d[16];
      amt_m  <= $signed(ka_d[15:0]);
    end
  end

  // Half angle in Q.30.
  logic signed [TW-1:0] th [0:3];
  logic signed [51:0]   prod_r;

  assign prod_r = (prod_m + 52'sd4096) >>> 13;

  always_ff @(posedge clk) begin
    if (adv) begin
      if (kind_m) begin
        th[0] <= TW'(amt_m) <<< 17;
      end else begin
        th[0] <= TW'(prod_r);
      end
    end
  end

  // Remainder by 2*pi, truncated toward zero, one subtraction per stage.
  localparam logic signed [TW-1:0] T_TWO_PI  = TW'(TWO_PI);
  localparam logic signed [TW-1:0] T_PI      = TW'(PI_Q30);
  localparam logic signed [TW-1:0] T_HALF_PI = TW'(HALF_PI);

  for (genvar g = 0; g < 3; g++) begin : g_mod
    always_ff @(posedge clk) begin
      if (adv) begin
        if (th[g] >= T_TWO_PI) begin
          th[g+1] <= th[g] - T_TWO_PI;
        end else if (th[g] <= -T_TWO_PI) begin
          th[g+1] <= th[g] + T_TWO_PI;
        end else begin
          th[g+1] <= th[g];
        end
      end
    end
  end

  // Wrap into [-pi, pi].
  logic signed [TW-1:0] thw;

  always_ff @(posedge clk) begin
    if (adv) begin
      if (th[3] > T_PI) begin
        thw <= th[3] - T_TWO_PI;
      end else if (th[3] < -T_PI) begin
        thw <= th[3] + T_TWO_PI;
      end else begin
        thw <= th[3];
      end
    end
  end

  // Fold into [-pi/2, pi/2] and start the sin/cos rotation.
  logic signed [CW-1:0] vr_x [0:N];
  logic signed [CW-1:0] vr_y [0:N];
  logic signed [CW-1:0] vr_z [0:N];
  logic                 flip_f;
  logic                 flip_d;

  always_ff @(posedge clk) begin
    if (adv) begin
      vr_x[0] <= GAIN_K;
      vr_y[0] <= '0;
      if (thw > T_HALF_PI) begin
        vr_z[0] <= CW'(thw - T_PI);
        flip_f  <= 1'b1;
      end else if (thw < -T_HALF_PI) begin
        vr_z[0] <= CW'(thw + T_PI);
        flip_f  <= 1'b1;
      end else begin
        vr_z[0] <= CW'(thw);
        flip_f  <= 1'b0;
      end
    end
  end

  for (genvar g = 0; g < N; g++) begin : g_sincos
    qfv_cordic_cell #(.IDX(g), .VECT(1'b0)) u_cell (
      .clk  (clk),
      .en   (adv),
      .x_in (vr_x[g]),
      .y_in (vr_y[g]),
      .z_in (vr_z[g]),
      .x_out(vr_x[g+1]),
      .y_out(vr_y[g+1]),
      .z_out(vr_z[g+1])
    );
  end

  qfv_delay #(.W(1), .DEPTH(N)) u_dly_flip (
    .clk(clk), .en(adv), .d(flip_f), .q(flip_d)
  );

  // Sine and cosine with the fold applied.
  logic signed [31:0] sn_a, cs_a, sn_t, cs_t;

  always_ff @(posedge clk) begin
    if (adv) begin
      sn_a <= flip_d ? -32'(vr_y[N]) : 32'(vr_y[N]);
      cs_a <= flip_d ? -32'(vr_x[N]) : 32'(vr_x[N]);
    end
  end

  // ---------------- Axis side ----------------

  // Stage 3: squares of the cross components; stage 4: their sum.
  logic [31:0]     mx2, my2, mz2;
  logic [63:0]     sqx, sqy, sqz;
  logic [SQ_W-1:0] sum4;

  assign mx2 = 32'(cx2[32] ? -cx2 : cx2);
  assign my2 = 32'(cy2[32] ? -cy2 : cy2);
  assign mz2 = 32'(cz2[32] ? -cz2 : cz2);

  always_ff @(posedge clk) begin
    if (adv) begin
      sqx  <= 64'(mx2) * 64'(mx2);
      sqy  <= 64'(my2) * 64'(my2);
      sqz  <= 64'(mz2) * 64'(mz2);
      sum4 <= sqx + sqy + sqz;
    end
  end

  // Stages 5 to 36: norm of the cross product.
  logic [SQ_W-1:0] sc_v [0:SQ_STEPS];
  logic [SQ_W-1:0] sc_r [0:SQ_STEPS];

  assign sc_v[0] = sum4;
  assign sc_r[0] = '0;
  for (genvar g = 0; g < SQ_STEPS; g++) begin : g_sqc
    qfv_sqrt_cell #(.IDX(g)) u_cell (
      .clk    (clk),
      .en     (adv),
      .v_in   (sc_v[g]),
      .res_in (sc_r[g]),
      .v_out  (sc_v[g+1]),
      .res_out(sc_r[g+1])
    );
  end

  logic [98:0] cr2, cr_d;

  assign cr2 = {cz2, cy2, cx2};
  qfv_delay #(.W(99), .DEPTH(34)) u_dly_cr (
    .clk(clk), .en(adv), .d(cr2), .q(cr_d)
  );

  // Stage 37: rounded dividend |c| * 2^30 + n/2 for each lane, then divider cells.
  logic [NW-1:0]   nrm;
  logic [2:0]      sgn37, sgn_d;
  logic [NW-1:0]   dv_rem [0:2][0:QW];
  logic [QW-1:0]   dv_low [0:2][0:QW];
  logic [QW-1:0]   dv_quo [0:2][0:QW];
  logic [NW-1:0]   dv_den [0:2][0:QW];

  assign nrm = sc_r[SQ_STEPS][NW-1:0];

  for (genvar l = 0; l < 3; l++) begin : g_lane
    logic signed [32:0] cl;
    logic [31:0]        ml;
    logic [61:0]        dnd;

    assign cl  = $signed(cr_d[33*l +: 33]);
    assign ml  = 32'(cl[32] ? -cl : cl);
    assign dnd = ({30'd0, ml} << 30) + 62'(nrm >> 1);

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_rem[l][0] <= NW'(dnd[61:QW]);
        dv_low[l][0] <= dnd[QW-1:0];
        dv_quo[l][0] <= '0;
        dv_den[l][0] <= nrm;
        sgn37[l]     <= cl[32];
      end
    end

    for (genvar g = 0; g < QW; g++) begin : g_div
      qfv_div_cell u_cell (
        .clk    (clk),
        .en     (adv),
        .rem_in (dv_rem[l][g]),
        .low_in (dv_low[l][g]),
        .quo_in (dv_quo[l][g]),
        .den_in (dv_den[l][g]),
        .rem_out(dv_rem[l][g+1]),
        .low_out(dv_low[l][g+1]),
        .quo_out(dv_quo[l][g+1]),
        .den_out(dv_den[l][g+1])
      );
    end
  end

  qfv_delay #(.W(3), .DEPTH(QW)) u_dly_sgn (
    .clk(clk), .en(adv), .d(sgn37), .q(sgn_d)
  );

  // Signed unit axis in Q.30.
  logic [95:0] axis_c, axis_t;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < 3; l++) begin
        axis_c[32*l +: 32] <= sgn_d[l] ? -{1'b0, dv_quo[l][QW]} : {1'b0, dv_quo[l][QW]};
      end
    end
  end

  // ---------------- Join ----------------

  logic zero_t;

  qfv_delay #(.W(96), .DEPTH(LT - LC)) u_dly_axis (
    .clk(clk), .en(adv), .d(axis_c), .q(axis_t)
  );
  qfv_delay #(.W(64), .DEPTH(LT - LA)) u_dly_sc (
    .clk(clk), .en(adv), .d({cs_a, sn_a}), .q({cs_t, sn_t})
  );
  qfv_delay #(.W(1), .DEPTH(LT - 2)) u_dly_zero (
    .clk(clk), .en(adv), .d(zero2), .q(zero_t)
  );

  // Axis times sine, one multiplier per lane.
  logic signed [63:0] pq [0:2];
  logic signed [31:0] cs_p;
  logic               zero_p;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < 3; l++) begin
        pq[l] <= 64'($signed(axis_t[32*l +: 32])) * 64'(sn_t);
      end
      cs_p   <= cs_t;
      zero_p <= zero_t;
    end
  end

  // Clamp to the Q1.14 unit range.
  function automatic logic [15:0] sat14(input logic signed [63:0] v);
    logic signed [63:0] r;
    begin
      r = v;
      if (v > 64'sd16384) r = 64'sd16384;
      if (v < -64'sd16384) r = -64'sd16384;
      return r[15:0];
    end
  endfunction

  logic signed [63:0] rx, ry, rz, rw;

  assign rx = (pq[0] + (64'sd1 <<< 45)) >>> 46;
  assign ry = (pq[1] + (64'sd1 <<< 45)) >>> 46;
  assign rz = (pq[2] + (64'sd1 <<< 45)) >>> 46;
  assign rw = (64'(cs_p) + 64'sd32768) >>> 16;

  // Output register.
  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata[15:0]  <= zero_p ? 16'd0 : sat14(rx);
      m_tdata[31:16] <= zero_p ? 16'd0 : sat14(ry);
      m_tdata[47:32] <= zero_p ? 16'd0 : sat14(rz);
      m_tdata[63:48] <= sat14(rw);
      m_tuser        <= zero_p;
    end
  end

endmodule

>>> test/quaternion_from_vector_pair_unit_tb.sv
// Self-checking testbench for quaternion_from_vector_pair_unit: drives vector pairs,
// predicts each quaternion in fixed point and compares it with the output stream.
// Depends on qfv_pkg and the RTL of the unit.
module quaternion_from_vector_pair_unit_tb
  import qfv_pkg::*;
;

  localparam int STEPS = (DEF_CORDIC_STEPS < ATAN_ENTRIES) ? DEF_CORDIC_STEPS : ATAN_ENTRIES;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 150;

  typedef struct packed {
    logic              kind;
    logic signed [15:0] fx, fy, fz, tx, ty, tz, amt;
  } rot_req_t;

  typedef struct packed {
    logic signed [15:0] qx, qy, qz, qw;
    logic               axis_zero;
  } quat_t;

  // Predicts one quaternion per accepted word and checks the outputs in order.
  class quat_scoreboard;
    longint atan_q[ATAN_ENTRIES];
    longint k_inv;
    quat_t  pending[$];
    int     errors;

    static function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    // atan(1/n) in Q.60 from the alternating series.
    static function longint unsigned atan_inv_q60(longint unsigned n);
      longint unsigned p, acc, k;
      bit neg;
      p = (64'd1 << 60) / n;
      acc = 0;
      k = 0;
      neg = 0;
      while (p != 0) begin
        if (neg) acc = acc - p / (2 * k + 1);
        else acc = acc + p / (2 * k + 1);
        neg = !neg;
        p = p / (n * n);
        k++;
      end
      return acc;
    endfunction

    function new();
      longint unsigned a, g2, g;
      for (int i = 0; i < ATAN_ENTRIES; i++) begin
        a = (i == 0) ? atan_inv_q60(2) + atan_inv_q60(3) : atan_inv_q60(64'd1 << i);
        atan_q[i] = longint'((a + (64'd1 << 29)) >> 30);
      end
      g2 = 64'd1 << 60;
      for (int i = 0; i < STEPS; i++) g2 = g2 + (g2 >> (2 * i));
      g = int_sqrt(g2);
      k_inv = longint'(((64'd1 << 60) + g / 2) / g);
      errors = 0;
    endfunction

    // Vectoring CORDIC: angle of (c, sqrt(1 - c^2)) in Q.30.
    function longint arc_cos(longint c);
      longint s, x, y, z, nx, ny;
      s = longint'(int_sqrt((64'd1 << 60) - longint'(c * c)));
      if (c < 0) begin
        x = s; y = -c; z = 2 * atan_q[0];
      end else begin
        x = c; y = s; z = 0;
      end
      for (int i = 0; i < STEPS; i++) begin
        if (y > 0) begin
          nx = x + (y >>> i); ny = y - (x >>> i); z = z + atan_q[i];
        end else begin
          nx = x - (y >>> i); ny = y + (x >>> i); z = z - atan_q[i];
        end
        x = nx; y = ny;
      end
      return z;
    endfunction

    // Rotation CORDIC after reducing the angle into [-pi/2, pi/2].
    function void sin_cos(longint th, output longint sn, output longint cs);
      longint pi_v, hp, tp, x, y, z, nx, ny;
      bit flip;
      pi_v = 4 * atan_q[0];
      hp = 2 * atan_q[0];
      tp = 8 * atan_q[0];
      x = k_inv;
      y = 0;
      flip = 0;
      z = th % tp;
      if (z > pi_v) z = z - tp;
      if (z < -pi_v) z = z + tp;
      if (z > hp) begin
        z = z - pi_v; flip = 1;
      end else if (z < -hp) begin
        z = z + pi_v; flip = 1;
      end
      for (int i = 0; i < STEPS; i++) begin
        if (z >= 0) begin
          nx = x - (y >>> i); ny = y + (x >>> i); z = z - atan_q[i];
        end else begin
          nx = x + (y >>> i); ny = y - (x >>> i); z = z + atan_q[i];
        end
        x = nx; y = ny;
      end
      sn = flip ? -y : y;
      cs = flip ? -x : x;
    endfunction

    static function logic signed [15:0] sat_q14(longint v);
      if (v > 16384) v = 16384;
      if (v < -16384) v = -16384;
      return v[15:0];
    endfunction

    static function longint unit_axis(longint c, longint n);
      longint unsigned m;
      longint q;
      m = (c < 0) ? -c : c;
      q = longint'(((m << 30) + longint'(n) / 2) / longint'(n));
      return (c < 0) ? -q : q;
    endfunction

    // Notes an accepted word and queues the quaternion that it must produce.
    function void note_request(rot_req_t rq);
      longint fx, fy, fz, tx, ty, tz, amt, d, th, sn, cs, cx, cy, cz, n, r;
      longint unsigned sum;
      quat_t q;
      fx = rq.fx; fy = rq.fy; fz = rq.fz;
      tx = rq.tx; ty = rq.ty; tz = rq.tz;
      amt = rq.amt;
      if (!rq.kind) begin
        d = fx * tx + fy * ty + fz * tz;
        // Dot products outside [-1, 1] are clamped.
        if (d > (64'sd1 <<< 28)) d = 64'sd1 <<< 28;
        if (d < -(64'sd1 <<< 28)) d = -(64'sd1 <<< 28);
        th = (arc_cos(d * 4) * amt + 4096) >>> 13;
      end else begin
        th = amt * 131072;
      end
      sin_cos(th, sn, cs);
      cx = fy * tz - fz * ty;
      cy = fz * tx - fx * tz;
      cz = fx * ty - fy * tx;
      q.axis_zero = (cx == 0 && cy == 0 && cz == 0);
      if (q.axis_zero) begin
        q.qx = 0; q.qy = 0; q.qz = 0;
      end else begin
        sum = longint'(cx * cx) + longint'(cy * cy) + longint'(cz * cz);
        n = longint'(int_sqrt(sum));
        r = 64'sd1 <<< 45;
        q.qx = sat_q14((unit_axis(cx, n) * sn + r) >>> 46);
        q.qy = sat_q14((unit_axis(cy, n) * sn + r) >>> 46);
        q.qz = sat_q14((unit_axis(cz, n) * sn + r) >>> 46);
      end
      q.qw = sat_q14((cs + 32768) >>> 16);
      pending.push_back(q);
    endfunction

    task report_mismatch(string what, longint got, longint want);
      $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
      errors++;
    endtask

    task check_result(quat_t got);
      quat_t want;
      if (pending.size() == 0) begin
        report_mismatch("unexpected word, quat_w", got.qw, 0);
      end else begin
        want = pending.pop_front();
        if (got.qx !== want.qx) report_mismatch("quat_x", got.qx, want.qx);
        if (got.qy !== want.qy) report_mismatch("quat_y", got.qy, want.qy);
        if (got.qz !== want.qz) report_mismatch("quat_z", got.qz, want.qz);
        if (got.qw !== want.qw) report_mismatch("quat_w", got.qw, want.qw);
        if (got.axis_zero !== want.axis_zero)
          report_mismatch("axis_zero", got.axis_zero, want.axis_zero);
      end
    endtask
  endclass

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [111:0] s_tdata;   // from_x, from_y, from_z, to_x, to_y, to_z, amount
  logic         s_tuser;   // kind
  logic         m_tvalid;
  logic         m_tready;
  logic [63:0]  m_tdata;   // quat_x, quat_y, quat_z, quat_w
  logic         m_tuser;   // axis_zero

  quat_scoreboard sb = new();
  int send_idle_pct;
  int stall_pct;
  int hold_requests;
  int hold_served;
  int hold_left;
  int cycle_count;

  quaternion_from_vector_pair_unit DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Receiver: random stalls, plus long hold-offs on request.
  always @(negedge clk) begin
    if (hold_requests != hold_served) begin
      hold_served = hold_requests;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready = 1'b0;
    end else begin
      m_tready = ($urandom_range(99) >= stall_pct);
    end
  end

  // Output monitor.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_result({m_tdata[15:0], m_tdata[31:16], m_tdata[47:32], m_tdata[63:48], m_tuser});
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Offers one word, with random idle cycles first, and waits for acceptance.
  task send_rotation(rot_req_t rq);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser = rq.kind;
    s_tdata = {rq.amt, rq.tz, rq.ty, rq.tx, rq.fz, rq.fy, rq.fx};
    do @(posedge clk); while (!s_tready);
    sb.note_request(rq);
    @(negedge clk);
    s_tvalid = 1'b0;
  endtask

  task send_fields(logic k, int fx, int fy, int fz, int tx, int ty, int tz, int amt);
    rot_req_t rq;
    rq.kind = k;
    rq.fx = 16'(fx); rq.fy = 16'(fy); rq.fz = 16'(fz);
    rq.tx = 16'(tx); rq.ty = 16'(ty); rq.tz = 16'(tz);
    rq.amt = 16'(amt);
    send_rotation(rq);
  endtask

  function automatic logic signed [15:0] rand_comp(int mode);
    case (mode)
      0: return 16'($urandom);
      1: return $signed(16'($urandom_range(32768))) - 16'sd16384;
      default: return $signed(16'($urandom_range(256))) - 16'sd128;
    endcase
  endfunction

  // Random word: full range, unit-scale, small, parallel or antiparallel pairs.
  task send_random;
    rot_req_t rq;
    int mode;
    int shape;
    mode = $urandom_range(2);
    shape = $urandom_range(9);
    rq.kind = 1'($urandom);
    rq.fx = rand_comp(mode); rq.fy = rand_comp(mode); rq.fz = rand_comp(mode);
    rq.tx = rand_comp(mode); rq.ty = rand_comp(mode); rq.tz = rand_comp(mode);
    if (shape == 0) begin
      rq.fx = rand_comp(2); rq.fy = rand_comp(2); rq.fz = rand_comp(2);
      rq.tx = 16'(rq.fx * 3); rq.ty = 16'(rq.fy * 3); rq.tz = 16'(rq.fz * 3);
    end else if (shape == 1) begin
      rq.tx = -rq.fx; rq.ty = -rq.fy; rq.tz = -rq.fz;
    end else if (shape == 2) begin
      rq.tx = rq.fx; rq.ty = rq.fy; rq.tz = rq.fz;
    end
    rq.amt = ($urandom_range(1)) ? 16'($urandom) : 16'($urandom_range(16384)) - 16'd8192;
    send_rotation(rq);
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = 1'b0;
    m_tready = 1'b0;
    send_idle_pct = 0;
    stall_pct = 0;
    hold_requests = 0;
    hold_served = 0;
    hold_left = 0;
    cycle_count = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed words: extremes, both kinds, parallel and zero vectors, clamped dots.
    send_fields(0, 16384, 0, 0, 0, 16384, 0, 4096);
    send_fields(1, 16384, 0, 0, 0, 16384, 0, 4096);
    send_fields(0, 16384, 0, 0, 16384, 0, 0, 4096);
    send_fields(0, 16384, 0, 0, -16384, 0, 0, 4096);
    send_fields(1, 0, 0, 0, 0, 0, 0, 12868);
    send_fields(0, 0, 0, 0, 0, 0, 0, 4096);
    send_fields(0, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
    send_fields(0, -32768, -32768, -32768, 32767, 32767, 32767, -32768);
    send_fields(0, -32768, 32767, -32768, 32767, -32768, 32767, 32767);
    send_fields(1, 32767, -32768, 0, 0, 32767, -32768, 32767);
    send_fields(1, -32768, 0, 32767, 32767, -32768, 0, -32768);
    send_fields(1, 0, 16384, 0, 0, 0, 16384, 0);
    send_fields(0, 0, 16384, 0, 0, 0, 16384, 0);
    send_fields(1, 16384, 0, 0, 0, 0, 16384, 25736);
    send_fields(1, 16384, 0, 0, 0, 0, 16384, -25736);
    send_fields(1, 0, 0, 16384, 16384, 0, 0, 6434);
    send_fields(0, 11585, 11585, 0, 16384, 0, 0, -4096);
    send_fields(0, 1, 0, 0, 0, 1, 0, 8192);
    send_fields(1, 1, 0, 0, 0, 1, 0, -1);

    // Random phases with different sender idling and receiver stalls, and one long receiver hold-off.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1) ? 68 : (ph == 3) ? 24 : 0;
      stall_pct = (ph == 2) ? 68 : (ph == 3) ? 24 : 0;
      for (int i = 0; i < 400; i++) begin
        if (ph == 0 && i == 100) hold_requests++;
        send_random();
      end
    end

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
